[sv/ascii_command_gpio_expander_assert.svh]
// assertion macros for the ascii command gpio expander
`ifndef ASCII_COMMAND_GPIO_EXPANDER_ASSERT_SVH
`define ASCII_COMMAND_GPIO_EXPANDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACGX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ACGX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/acgx_pkg.sv]
// shared types, constants and helper functions of the gpio expander
`default_nettype none
package acgx_pkg;

  localparam int CHANNELS = 16;
  localparam logic [15:0] CHAN_MASK = 16'((33'd1 << CHANNELS) - 33'd1);
  localparam int MAX_BYTES = 6;

  // io_mode codes
  localparam logic [1:0] MODE_IN  = 2'd0;
  localparam logic [1:0] MODE_OUT = 2'd1;

  // configuration register indexes
  localparam logic CFG_IO_MODE = 1'b0;
  localparam logic CFG_VERBOSE = 1'b1;

  // ascii codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_Q  = 8'h51;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;

  // hex value marking a non-hex character
  localparam logic [4:0] HEX_BAD = 5'd16;

  // one queued request: reply bytes plus state snapshot after the request
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic [15:0]               dout;
    logic                      quit;
    logic                      cont;
  } entry_t;

  // queue status toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // ascii character to hex value, HEX_BAD if not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= CH_ZERO && c <= CH_NINE) v = 5'(c - CH_ZERO);
    else if (c >= CH_UP_A && c <= CH_UP_F) v = 5'(c - CH_UP_A + 8'd10);
    else if (c >= CH_LO_A && c <= CH_LO_F) v = 5'(c - CH_LO_A + 8'd10);
    return v;
  endfunction

  // nibble to uppercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'd0, d};
    else c = CH_UP_A + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/ascii_command_gpio_expander.sv]
// top level of the ascii command gpio expander
// A 16-channel I/O block run by decoded ASCII commands and report ticks.
// Each request yields up to six reply bytes, one per cycle through the
// output register while out_stall is low; a request with no reply yields
// one result with byte_valid low and last high. The front end decodes a
// request and updates the output levels, report flag and quit flag in the
// cycle it is taken, and can take one request per cycle while its two-entry
// queue has room, so the sustained rate is set by the output serializer.
// Configuration writes (io_mode at index 0, verbose at index 1) take effect
// on the next cycle. The user must make them only while no request is in
// flight; the block itself does not enforce this.
`default_nettype none
module ascii_command_gpio_expander import acgx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [4:0]  cmd_length,
  input  wire logic [7:0]  char_0,
  input  wire logic [7:0]  char_1,
  input  wire logic [7:0]  char_2,
  input  wire logic [7:0]  char_3,
  input  wire logic [7:0]  char_4,
  input  wire logic [15:0] din_levels,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             byte_valid,
  output logic [7:0]       reply_byte,
  output logic             last,
  output logic [15:0]      dout_levels,
  output logic             quit_request,
  output logic             continuous_on
);

`include "ascii_command_gpio_expander_assert.svh"

  entry_t     entry;
  entry_t     head;
  fifo_stat_t fifo_stat;
  logic       accept;
  logic       pop;

  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;

  // decode
  acgx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .func       (func),
    .cmd_length (cmd_length),
    .char_0     (char_0),
    .char_1     (char_1),
    .char_2     (char_2),
    .char_3     (char_3),
    .char_4     (char_4),
    .din_levels (din_levels),
    .entry      (entry)
  );

  // request queue
  acgx_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  // reply serializer
  acgx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (fifo_stat),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .byte_valid    (byte_valid),
    .reply_byte    (reply_byte),
    .last          (last),
    .dout_levels   (dout_levels),
    .quit_request  (quit_request),
    .continuous_on (continuous_on)
  );

  // checks
  `ACGX_ASSERT_NEXT(a_quit_sticky, quit_request, quit_request, "quit flag cleared")
  `ACGX_ASSERT_NOW(a_no_byte, out_valid && !byte_valid, last && reply_byte == 8'd0, "bad no-byte")
  `ACGX_ASSERT_NEXT(a_drain, !fifo_stat.empty && (!out_valid || !out_stall), out_valid, "stuck")

endmodule
`default_nettype wire

[sv/acgx_front.sv]
// front end: takes requests, decodes commands, updates state, builds replies
`default_nettype none
module acgx_front import acgx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        accept,
  input  wire logic        func,
  input  wire logic [4:0]  cmd_length,
  input  wire logic [7:0]  char_0,
  input  wire logic [7:0]  char_1,
  input  wire logic [7:0]  char_2,
  input  wire logic [7:0]  char_3,
  input  wire logic [7:0]  char_4,
  input  wire logic [15:0] din_levels,
  output entry_t           entry
);

  logic [1:0]  io_mode;
  logic        verbose;
  logic [15:0] levels, levels_next;
  logic        report, report_next;
  logic        quit, quit_next;

  logic        din_ok, dout_ok;
  logic [15:0] din_m;
  logic [4:0]  h1, h2, h3, h4;
  logic [MAX_BYTES-1:0][7:0] b;
  logic [2:0]  n;

  assign din_ok  = (io_mode == MODE_IN);
  assign dout_ok = (io_mode == MODE_OUT);
  assign din_m   = din_levels & CHAN_MASK;
  assign h1 = hex_val(char_1);
  assign h2 = hex_val(char_2);
  assign h3 = hex_val(char_3);
  assign h4 = hex_val(char_4);

  // command decode and reply build
  always_comb begin
    levels_next = levels;
    report_next = report;
    quit_next   = quit;
    b = '0;
    n = 3'd0;
    if (func) begin
      if (report && din_ok) begin
        b = {CH_STAR, hex_char(din_m[3:0]), hex_char(din_m[7:4]),
             hex_char(din_m[11:8]), hex_char(din_m[15:12]), CH_LO_R};
        n = 3'd6;
      end
    end else if (cmd_length != 5'd0) begin
      case (char_0) inside
        CH_UP_R, CH_LO_R: begin
          if (cmd_length != 5'd1 || !din_ok) begin
            b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
          end else if (char_0 == CH_LO_R) begin
            report_next = 1'b1;
          end else begin
            report_next = 1'b0;
            b = {CH_STAR, hex_char(din_m[3:0]), hex_char(din_m[7:4]),
                 hex_char(din_m[11:8]), hex_char(din_m[15:12]), CH_UP_R};
            n = 3'd6;
          end
        end
        CH_UP_D: begin
          if (cmd_length != 5'd5 || !dout_ok || h1[4] || h2[4] || h3[4] || h4[4]) begin
            b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
          end else begin
            levels_next = {h1[3:0], h2[3:0], h3[3:0], h4[3:0]} & CHAN_MASK;
            if (verbose) begin
              b = {CH_STAR, char_4, char_3, char_2, char_1, CH_UP_D};
              n = 3'd6;
            end
          end
        end
        CH_UP_H, CH_UP_L: begin
          if (cmd_length != 5'd2 || !dout_ok || h1[4] ||
              32'(h1) >= 32'(CHANNELS)) begin
            b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
          end else begin
            levels_next[h1[3:0]] = (char_0 == CH_UP_H);
            levels_next = levels_next & CHAN_MASK;
            if (verbose) begin
              b[0] = char_0; b[1] = char_1; b[2] = CH_STAR; n = 3'd3;
            end
          end
        end
        CH_UP_E: begin
          if (cmd_length != 5'd1) begin
            b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
          end else begin
            report_next = 1'b0;
            b[0] = CH_UP_E; b[1] = CH_STAR; n = 3'd2;
          end
        end
        CH_UP_Q: begin
          if (cmd_length != 5'd1) begin
            b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
          end else begin
            quit_next = 1'b1;
            b[0] = CH_UP_Q; b[1] = CH_STAR; n = 3'd2;
          end
        end
        default: begin
          b[0] = CH_BANG; b[1] = CH_STAR; n = 3'd2;
        end
      endcase
    end
  end

  // queue entry carries the state as it stands after this request
  always_comb begin
    entry.bytes  = b;
    entry.nbytes = n;
    entry.dout   = levels_next;
    entry.quit   = quit_next;
    entry.cont   = report_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      io_mode <= MODE_IN;
      verbose <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_IO_MODE) io_mode <= cfg_data;
      else verbose <= cfg_data[0];
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      report <= 1'b0;
      quit   <= 1'b0;
    end else if (accept) begin
      levels <= levels_next;
      report <= report_next;
      quit   <= quit_next;
    end
  end

endmodule
`default_nettype wire

[sv/acgx_fifo.sv]
// two-entry queue between decode and reply serializer
`default_nettype none
module acgx_fifo import acgx_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      head,
  output fifo_stat_t  stat
);

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[sv/acgx_back.sv]
// back end: sends queued replies one byte per cycle through the output register while out_stall is low
`default_nettype none
module acgx_back import acgx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire entry_t      head,
  input  wire fifo_stat_t  stat,
  output logic             pop,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic             byte_valid,
  output logic [7:0]       reply_byte,
  output logic             last,
  output logic [15:0]      dout_levels,
  output logic             quit_request,
  output logic             continuous_on
);

  logic [2:0] idx;
  logic       load;
  logic       has_bytes;
  logic       is_last;

  assign load      = !out_valid || !out_stall;
  assign has_bytes = (head.nbytes != 3'd0);
  assign is_last   = !has_bytes || (idx == head.nbytes - 3'd1);
  assign pop       = load && !stat.empty && is_last;

  // byte index within the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (load && !stat.empty) begin
      idx <= is_last ? 3'd0 : idx + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      byte_valid    <= 1'b0;
      reply_byte    <= '0;
      last          <= 1'b0;
      dout_levels   <= '0;
      quit_request  <= 1'b0;
      continuous_on <= 1'b0;
    end else if (load) begin
      out_valid <= !stat.empty;
      if (!stat.empty) begin
        byte_valid    <= has_bytes;
        reply_byte    <= has_bytes ? head.bytes[idx] : 8'd0;
        last          <= is_last;
        dout_levels   <= head.dout;
        quit_request  <= head.quit;
        continuous_on <= head.cont;
      end
    end
  end

endmodule
`default_nettype wire
